### hdl/fbh_pkg.sv
// ----------------------------------------------------------------------------
// fbh_pkg: shared types and constants for the fixed-bin pixel histogram
// Beat formats of both channels, configuration register layout and the
// internal beats passed between the bin mapper, counter bank and readout.
// ----------------------------------------------------------------------------
`default_nettype none

package fbh_pkg;

  // Storage geometry
  localparam int unsigned MAX_BINS = 64;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned BIN_W    = $clog2(MAX_BINS);
  localparam int unsigned NB_W     = $clog2(MAX_BINS + 1);

  // Field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SPAN_W = 9;
  localparam int unsigned CNT_CFG_W = 7;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_RANGE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WINDOW  = 2'd3;

  // Input beat: one pixel
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } pix_beat_t;

  // Output beat: one bin of the readout
  typedef struct packed {
    logic [BIN_W-1:0]   bin_index;
    logic [COUNT_W-1:0] bin_total;
    logic               last_bin;
  } bin_beat_t;

  // Configuration registers
  typedef struct packed {
    logic [CNT_CFG_W-1:0] bin_count;
    logic [PIX_W-1:0]     bin_offset;
    logic [SPAN_W-1:0]    value_range;
    logic [SPAN_W-1:0]    bin_window;
  } cfg_t;

  // Bin mapper to counter bank
  typedef struct packed {
    logic             vld;
    logic             cnt_en;
    logic [BIN_W-1:0] idx;
    logic             frame_end;
  } map_beat_t;

  // Readout read request into the counter bank
  typedef struct packed {
    logic             req;
    logic [BIN_W-1:0] addr;
  } rd_req_t;

endpackage

`default_nettype wire

### hdl/fbh_bin_map.sv
// ----------------------------------------------------------------------------
// fbh_bin_map: pixel to bin index mapping
// Range check against offset/range, then a two-stage restoring divide by the
// bin window (four quotient bits per stage) and a check against bins in use.
// ----------------------------------------------------------------------------
`default_nettype none

module fbh_bin_map import fbh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pix_vld_i,
  input  pix_beat_t           pix_i,
  input  cfg_t                cfg_i,
  input  logic [NB_W-1:0]     nb_i,
  output map_beat_t           map_o
);

  localparam int unsigned HALF_W = PIX_W / 2;

  typedef struct packed {
    logic              vld;
    logic              in_rng;
    logic              frame_end;
    logic [SPAN_W-1:0] rem;
    logic [HALF_W-1:0] q_hi;
    logic [HALF_W-1:0] rel_lo;
  } div_beat_t;

  logic [SPAN_W-1:0] win;
  div_beat_t         div_d, div_q;
  map_beat_t         map_d, map_q;

  // Window of zero acts as a window of one
  assign win = (cfg_i.bin_window == '0) ? SPAN_W'(1) : cfg_i.bin_window;

  // Range check and upper quotient bits
  always_comb begin
    logic [PIX_W-1:0]  rel;
    logic [SPAN_W-1:0] rem;
    rel = pix_i.pixel - cfg_i.bin_offset;
    rem = '0;
    div_d.q_hi = '0;
    for (int k = 0; k < HALF_W; k++) begin
      rem = {rem[SPAN_W-2:0], rel[PIX_W-1-k]};
      if (rem >= win) begin
        rem = rem - win;
        div_d.q_hi[HALF_W-1-k] = 1'b1;
      end
    end
    div_d.vld       = pix_vld_i;
    div_d.in_rng    = (pix_i.pixel >= cfg_i.bin_offset) &&
                      ({1'b0, rel} < cfg_i.value_range);
    div_d.frame_end = pix_i.frame_end;
    div_d.rem       = rem;
    div_d.rel_lo    = rel[HALF_W-1:0];
  end

  // Lower quotient bits and bin count check
  always_comb begin
    logic [SPAN_W-1:0] rem;
    logic [HALF_W-1:0] q_lo;
    logic [PIX_W-1:0]  quo;
    rem  = div_q.rem;
    q_lo = '0;
    for (int k = 0; k < HALF_W; k++) begin
      rem = {rem[SPAN_W-2:0], div_q.rel_lo[HALF_W-1-k]};
      if (rem >= win) begin
        rem = rem - win;
        q_lo[HALF_W-1-k] = 1'b1;
      end
    end
    quo = {div_q.q_hi, q_lo};
    map_d.vld       = div_q.vld;
    map_d.cnt_en    = div_q.vld && div_q.in_rng &&
                      ({{(PIX_W + 1 - NB_W){1'b0}}, nb_i} > {1'b0, quo});
    map_d.idx       = quo[BIN_W-1:0];
    map_d.frame_end = div_q.frame_end;
  end

  // Advance both stages every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
      map_q <= '0;
    end else begin
      div_q <= div_d;
      map_q <= map_d;
    end
  end

  assign map_o = map_q;

endmodule

`default_nettype wire

### hdl/fbh_counter_bank.sv
// ----------------------------------------------------------------------------
// fbh_counter_bank: bin counter memory with read-modify-write
// One synchronous RAM of counters, a valid bit per entry (invalid reads as
// zero), saturating increment in the cycle after the read, and forwarding of
// the write-back when back-to-back pixels hit the same bin.
// ----------------------------------------------------------------------------
`default_nettype none

module fbh_counter_bank import fbh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  map_beat_t          map_i,
  input  rd_req_t            rd_req_i,
  input  logic               clear_i,
  output logic [COUNT_W-1:0] rd_total_o,
  output logic               done_o
);

  logic [COUNT_W-1:0] mem_q [MAX_BINS];
  logic [COUNT_W-1:0] rdata_q;
  logic [MAX_BINS-1:0] vld_q;
  map_beat_t          wb_q;
  logic               rvld_q, rvld_d;
  logic               hit_q, hit_d;
  logic [COUNT_W-1:0] fwd_q;

  logic               rd_en;
  logic [BIN_W-1:0]   rd_addr;
  logic               wr_en;
  logic [COUNT_W-1:0] old_total;
  logic [COUNT_W-1:0] new_total;

  // Share the read port between counting and readout
  assign rd_en   = map_i.cnt_en || rd_req_i.req;
  assign rd_addr = map_i.cnt_en ? map_i.idx : rd_req_i.addr;

  // Pick forwarded value, stored value or zero for an unwritten entry
  assign old_total = hit_q ? fwd_q : (rvld_q ? rdata_q : '0);
  assign wr_en     = wb_q.cnt_en;
  assign new_total = (&old_total) ? old_total : old_total + COUNT_W'(1);

  assign hit_d  = wr_en && rd_en && (wb_q.idx == rd_addr);
  assign rvld_d = vld_q[rd_addr];

  // Counter memory
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wb_q.idx] <= new_total;
    end
    fwd_q <= new_total;
  end

  // Write-back stage, valid bits and forwarding control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q   <= '0;
      vld_q  <= '0;
      rvld_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      wb_q <= map_i;
      if (rd_en) begin
        rvld_q <= rvld_d;
        hit_q  <= hit_d;
      end
      if (clear_i) begin
        vld_q <= '0;
      end
      if (wr_en) begin
        vld_q[wb_q.idx] <= 1'b1;
      end
    end
  end

  assign rd_total_o = old_total;
  assign done_o     = wb_q.vld && wb_q.frame_end;

  // Readout never competes with a counting read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_req_i.req && map_i.cnt_en))
    else $error("readout read collides with counting read");

  // Clearing never drops a pending increment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clear_i && wr_en))
    else $error("counter clear during write-back");

endmodule

`default_nettype wire

### hdl/fbh_readout.sv
// ----------------------------------------------------------------------------
// fbh_readout: end-of-frame readout sequencer
// Walks the bins in use through the counter bank read port, loads each
// count into the output register and clears the bank after the last read.
// ----------------------------------------------------------------------------
`default_nettype none

module fbh_readout import fbh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NB_W-1:0]    nb_i,
  input  logic [COUNT_W-1:0] rd_total_i,
  output rd_req_t            rd_req_o,
  output logic               clear_o,
  output logic               fin_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bin_beat_t          out_beat_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e           st_q;
  logic [NB_W-1:0]  ptr_q;
  logic             infl_q;
  logic             infl_last_q;
  logic [BIN_W-1:0] infl_idx_q;
  logic             out_vld_q;
  bin_beat_t        out_q;

  logic             out_free;
  logic             issue;
  logic             issue_last;
  logic             start_empty;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign issue       = (st_q == ST_RUN) && !infl_q && out_free && (ptr_q < nb_i);
  assign issue_last  = (ptr_q + NB_W'(1)) == nb_i;
  assign start_empty = (st_q == ST_IDLE) && start_i && (nb_i == '0);

  assign rd_req_o.req  = issue;
  assign rd_req_o.addr = ptr_q[BIN_W-1:0];

  // Finish when the last read returns, or at once with no bins in use
  assign clear_o = start_empty || (infl_q && infl_last_q);
  assign fin_o   = clear_o;

  // Sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ptr_q       <= '0;
      infl_q      <= 1'b0;
      infl_last_q <= 1'b0;
      infl_idx_q  <= '0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (start_i && (nb_i != '0)) begin
            st_q  <= ST_RUN;
            ptr_q <= '0;
          end
        end
        ST_RUN: begin
          if (infl_q && infl_last_q) begin
            st_q <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase

      // Track the read in flight
      infl_q <= issue;
      if (issue) begin
        infl_last_q <= issue_last;
        infl_idx_q  <= ptr_q[BIN_W-1:0];
        ptr_q       <= ptr_q + NB_W'(1);
      end

      // Load returned count, drop accepted beat
      if (infl_q) begin
        out_vld_q       <= 1'b1;
        out_q.bin_index <= infl_idx_q;
        out_q.bin_total <= rd_total_i;
        out_q.last_bin  <= infl_last_q;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

  // A returning read always finds the output register free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    infl_q |-> !out_vld_q)
    else $error("read data returns into a full output register");

  // The final bin is loaded as the sequencer goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (infl_q && infl_last_q) |=> (st_q == ST_IDLE) && out_vld_q && out_q.last_bin)
    else $error("last bin loaded without ending the readout");

endmodule

`default_nettype wire

### hdl/fixed_bin_pixel_histogram.sv
// ----------------------------------------------------------------------------
// fixed_bin_pixel_histogram: fixed-bin histogram of 8-bit pixels
// Counts each frame's pixels into up to 64 saturating 32-bit bins held in a
// synchronous RAM and reads the bins out in order at the end of the frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock while counting: each pixel passes a range
// check, a two-stage divide by the bin window and a read-modify-write of its
// counter RAM entry, with forwarding so equal bins in a row count correctly.
// The pixel marked frame_end stalls the input until the readout has read
// every bin: the pipeline drains, then each bin in use costs one read of the
// single RAM read port and waits for that read to return, and the readout
// waits longer while the output is stalled. The counters are cleared at the
// end of each readout through per-entry valid bits, so there is no clearing
// pass after reset. Write configuration only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_bin_pixel_histogram import fbh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pix_beat_t             in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bin_beat_t             out_beat_o
);

  cfg_t               cfg_q;
  logic [NB_W-1:0]    nb;
  logic               busy_q;
  logic               in_acc;
  logic               pix_vld_q;
  pix_beat_t          pix_q;
  map_beat_t          map;
  rd_req_t            rd_req;
  logic [COUNT_W-1:0] rd_total;
  logic               done;
  logic               clear;
  logic               fin;

  // Bins in use, capped at the storage depth
  assign nb = ({1'b0, cfg_q.bin_count} > (CNT_CFG_W + 1)'(MAX_BINS)) ?
              NB_W'(MAX_BINS) : NB_W'(cfg_q.bin_count);

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bin_count   <= CNT_CFG_W'(16);
      cfg_q.bin_offset  <= '0;
      cfg_q.value_range <= SPAN_W'(256);
      cfg_q.bin_window  <= SPAN_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BIN_COUNT:   cfg_q.bin_count   <= cfg_data_i[CNT_CFG_W-1:0];
        CFG_BIN_OFFSET:  cfg_q.bin_offset  <= cfg_data_i[PIX_W-1:0];
        CFG_VALUE_RANGE: cfg_q.value_range <= cfg_data_i[SPAN_W-1:0];
        CFG_BIN_WINDOW:  cfg_q.bin_window  <= cfg_data_i[SPAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register and frame busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
      pix_q     <= '0;
      busy_q    <= 1'b0;
    end else begin
      pix_vld_q <= in_acc;
      if (in_acc) begin
        pix_q <= in_beat_i;
      end
      if (in_acc && in_beat_i.frame_end) begin
        busy_q <= 1'b1;
      end else if (fin) begin
        busy_q <= 1'b0;
      end
    end
  end

  fbh_bin_map u_bin_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_vld_i (pix_vld_q),
    .pix_i     (pix_q),
    .cfg_i     (cfg_q),
    .nb_i      (nb),
    .map_o     (map)
  );

  fbh_counter_bank u_counter_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .map_i      (map),
    .rd_req_i   (rd_req),
    .clear_i    (clear),
    .rd_total_o (rd_total),
    .done_o     (done)
  );

  fbh_readout u_readout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (done),
    .nb_i        (nb),
    .rd_total_i  (rd_total),
    .rd_req_o    (rd_req),
    .clear_o     (clear),
    .fin_o       (fin),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire
